/* rtl/mtcc_pkg.sv */
// ----------------------------------------------------------------------------
// mtcc_pkg
// types and constants shared by the two-cache msi coherence core
// ----------------------------------------------------------------------------
`default_nettype none

package mtcc_pkg;

  localparam int ADDR_BITS = 9;
  localparam int LINE_BITS = 8;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_M = 2'd2
  } coh_state_t;

  typedef enum logic [2:0] {
    BUS_NONE    = 3'd0,
    BUS_READ    = 3'd1,
    BUS_RIM     = 3'd2,
    BUS_INV     = 3'd3,
    BUS_READ_WB = 3'd4,
    BUS_RIM_WB  = 3'd5
  } bus_action_t;

  typedef enum logic [2:0] {
    CTL_CLEAR = 3'b001,
    CTL_IDLE  = 3'b010,
    CTL_READ  = 3'b100
  } ctl_state_t;

  typedef struct packed {
    logic                 is_write;
    logic                 requester;
    logic [LINE_BITS-1:0] line;
  } coh_req_t;

  typedef struct packed {
    logic        hit;
    bus_action_t bus;
    logic        wb;
    coh_state_t  req_state;
    coh_state_t  snp_state;
  } coh_result_t;

endpackage

`default_nettype wire

/* rtl/mtcc_ifs.sv */
// ----------------------------------------------------------------------------
// mtcc channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mtcc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       requester;
  logic [8:0] word_addr;

  modport source (output valid, req_type, requester, word_addr, input ready);
  modport sink   (input valid, req_type, requester, word_addr, output ready);
endinterface

interface mtcc_rsp_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [2:0]           bus_action;
  logic                 requester_writeback;
  logic [1:0]           requester_state;
  logic [1:0]           snooper_state;
  logic [7:0]           line_index;
  logic [WORD_BITS-1:0] word_even;
  logic [WORD_BITS-1:0] word_odd;

  modport source (
    output valid, hit, bus_action, requester_writeback, requester_state,
           snooper_state, line_index, word_even, word_odd,
    input  ready
  );
  modport sink (
    input  valid, hit, bus_action, requester_writeback, requester_state,
           snooper_state, line_index, word_even, word_odd,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/mtcc_word_mem.sv */
// ----------------------------------------------------------------------------
// mtcc_word_mem
// shared word memory, two registered read ports, one write port, clearing
// pass after reset
// ----------------------------------------------------------------------------
`default_nettype none

module mtcc_word_mem #(
  parameter int MEM_WORDS = 512,
  parameter int WORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MEM_WORDS)-1:0] rd_addr_a,
  input  wire logic [$clog2(MEM_WORDS)-1:0] rd_addr_b,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MEM_WORDS)-1:0] wr_addr,
  input  wire logic [WORD_BITS-1:0]         wr_data,
  output logic      [WORD_BITS-1:0]         rd_data_a,
  output logic      [WORD_BITS-1:0]         rd_data_b,
  output logic                              clear_done
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [WORD_BITS-1:0] mem [MEM_WORDS];
  logic [AW-1:0]        clr_cnt_r;
  logic [AW-1:0]        clr_cnt_nxt;
  logic                 clr_busy_r;
  logic                 clr_busy_nxt;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

  assign clear_done = !clr_busy_r;

endmodule

`default_nettype wire

/* rtl/mtcc_coh_ctrl.sv */
// ----------------------------------------------------------------------------
// mtcc_coh_ctrl
// per-processor line tag and msi state, requester and snooper transitions
// ----------------------------------------------------------------------------
`default_nettype none

module mtcc_coh_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mtcc_pkg::coh_req_t   req,
  input  wire logic                 update,
  output mtcc_pkg::coh_result_t     result
);

  import mtcc_pkg::*;

  coh_state_t           st0_r, st1_r;
  coh_state_t           st0_nxt, st1_nxt;
  logic [LINE_BITS-1:0] tag0_r, tag1_r;
  logic [LINE_BITS-1:0] tag0_nxt, tag1_nxt;

  coh_state_t           my_st;
  coh_state_t           ot_st;
  logic [LINE_BITS-1:0] my_tag;
  logic [LINE_BITS-1:0] ot_tag;
  logic                 hit;
  bus_action_t          bus;
  bus_action_t          bus_final;
  logic                 wb;
  coh_state_t           ns;
  coh_state_t           ot_ns;

  always_comb begin
    my_st  = req.requester ? st1_r  : st0_r;
    ot_st  = req.requester ? st0_r  : st1_r;
    my_tag = req.requester ? tag1_r : tag0_r;
    ot_tag = req.requester ? tag0_r : tag1_r;

    hit = (my_st != ST_I) && (my_tag == req.line);
    bus = BUS_NONE;
    wb  = 1'b0;
    if (hit) begin
      if (req.is_write) begin
        bus = (my_st == ST_M) ? BUS_NONE : BUS_INV;
        ns  = ST_M;
      end else begin
        ns = (my_st == ST_M) ? ST_M : ST_S;
      end
    end else begin
      wb = (my_st == ST_M);
      if (req.is_write) begin
        bus = BUS_RIM;
        ns  = ST_M;
      end else begin
        bus = BUS_READ;
        ns  = ST_S;
      end
    end

    // snoop on the other cache
    ot_ns     = ot_st;
    bus_final = bus;
    if ((bus != BUS_NONE) && (ot_st != ST_I) && (ot_tag == req.line)) begin
      if (ot_st == ST_M) begin
        case (bus)
          BUS_READ: begin
            ot_ns     = ST_S;
            bus_final = BUS_READ_WB;
          end
          BUS_RIM: begin
            ot_ns     = ST_I;
            bus_final = BUS_RIM_WB;
          end
          default: begin
            ot_ns = ST_I;
          end
        endcase
      end else if (bus != BUS_READ) begin
        ot_ns = ST_I;
      end
    end

    st0_nxt  = st0_r;
    st1_nxt  = st1_r;
    tag0_nxt = tag0_r;
    tag1_nxt = tag1_r;
    if (update) begin
      if (req.requester) begin
        st1_nxt  = ns;
        tag1_nxt = req.line;
        st0_nxt  = ot_ns;
      end else begin
        st0_nxt  = ns;
        tag0_nxt = req.line;
        st1_nxt  = ot_ns;
      end
    end

    result.hit       = hit;
    result.bus       = bus_final;
    result.wb        = wb;
    result.req_state = ns;
    result.snp_state = ot_ns;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_r  <= ST_I;
      st1_r  <= ST_I;
      tag0_r <= '0;
      tag1_r <= '0;
    end else begin
      st0_r  <= st0_nxt;
      st1_r  <= st1_nxt;
      tag0_r <= tag0_nxt;
      tag1_r <= tag1_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/msi_two_cache_coherence_core.sv */
// ----------------------------------------------------------------------------
// msi_two_cache_coherence_core
// two one-line caches kept coherent by msi snooping over a shared word memory
// ----------------------------------------------------------------------------
// Each transaction is a read or write (increment) by processor 0 or 1 to a
// word address; one response per transaction reports hit, bus action,
// requester write-back, both cache states and the two words of the line
// after the access. The word memory is read on acceptance (synchronous read);
// in state CTL_READ, once the response register is free, the addressed word
// is incremented and written back on a write and the response register
// loaded, after which the next transaction is taken. A new transaction is
// accepted while a response still waits. After reset a clearing pass zeroes
// the memory, one word per cycle, with no transaction accepted meanwhile.
// Word addresses wrap modulo MEM_WORDS.
// ----------------------------------------------------------------------------
`default_nettype none

module msi_two_cache_coherence_core #(
  parameter int MEM_WORDS = 512,
  parameter int WORD_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mtcc_req_if.sink    in_req,
  mtcc_rsp_if.source  out_rsp
);

  import mtcc_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  function automatic logic [AW-1:0] word_index(input logic [ADDR_BITS:0] v);
    int rem;
    rem = int'(v);
    for (int k = ADDR_BITS; k >= 0; k--) begin
      if (rem >= (MEM_WORDS << k)) begin
        rem = rem - (MEM_WORDS << k);
      end
    end
    return AW'(rem);
  endfunction

  ctl_state_t state_r, state_nxt;

  logic                 req_write_r;
  logic                 req_id_r;
  logic [ADDR_BITS-1:0] req_addr_r;
  logic [AW-1:0]        widx_r;

  logic [AW-1:0]        eidx;
  logic [AW-1:0]        oidx;
  logic                 accept;
  logic                 out_free;
  logic                 complete;
  logic                 clear_done;
  logic [WORD_BITS-1:0] rd_a;
  logic [WORD_BITS-1:0] rd_b;
  logic [WORD_BITS-1:0] inc_word;

  coh_req_t    coh_req;
  coh_result_t coh_res;

  logic                 out_valid_r, out_valid_nxt;
  coh_result_t          res_r;
  logic [LINE_BITS-1:0] line_r;
  logic [WORD_BITS-1:0] even_r;
  logic [WORD_BITS-1:0] odd_r;

  assign eidx = word_index({1'b0, in_req.word_addr[ADDR_BITS-1:1], 1'b0});
  assign oidx = word_index({1'b0, in_req.word_addr[ADDR_BITS-1:1], 1'b1});

  assign in_req.ready = (state_r == CTL_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign complete     = (state_r == CTL_READ) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CTL_CLEAR: begin
        if (clear_done) state_nxt = CTL_IDLE;
      end
      CTL_IDLE: begin
        if (accept) state_nxt = CTL_READ;
      end
      CTL_READ: begin
        if (out_free) state_nxt = CTL_IDLE;
      end
      default: begin
        state_nxt = CTL_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_write_r <= in_req.req_type;
      req_id_r    <= in_req.requester;
      req_addr_r  <= in_req.word_addr;
      widx_r      <= in_req.word_addr[0] ? oidx : eidx;
    end
  end

  mtcc_word_mem #(
    .MEM_WORDS (MEM_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr_a  (eidx),
    .rd_addr_b  (oidx),
    .wr_en      (complete && req_write_r),
    .wr_addr    (widx_r),
    .wr_data    (inc_word),
    .rd_data_a  (rd_a),
    .rd_data_b  (rd_b),
    .clear_done (clear_done)
  );

  assign inc_word = (req_addr_r[0] ? rd_b : rd_a) + WORD_BITS'(1);

  assign coh_req.is_write  = req_write_r;
  assign coh_req.requester = req_id_r;
  assign coh_req.line      = req_addr_r[ADDR_BITS-1:1];

  mtcc_coh_ctrl u_coh (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (coh_req),
    .update (complete),
    .result (coh_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (complete) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      res_r  <= coh_res;
      line_r <= req_addr_r[ADDR_BITS-1:1];
      even_r <= (req_write_r && !req_addr_r[0]) ? inc_word : rd_a;
      odd_r  <= (req_write_r && req_addr_r[0])  ? inc_word : rd_b;
    end
  end

  assign out_rsp.valid               = out_valid_r;
  assign out_rsp.hit                 = res_r.hit;
  assign out_rsp.bus_action          = res_r.bus;
  assign out_rsp.requester_writeback = res_r.wb;
  assign out_rsp.requester_state     = res_r.req_state;
  assign out_rsp.snooper_state       = res_r.snp_state;
  assign out_rsp.line_index          = line_r;
  assign out_rsp.word_even           = even_r;
  assign out_rsp.word_odd            = odd_r;

endmodule

`default_nettype wire

/* rtl/mtcc_checker.sv */
// ----------------------------------------------------------------------------
// mtcc_checker
// port-level checks on the coherence core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mtcc_checker #(
  parameter int WORD_BITS = 32
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 hit,
  input wire logic [2:0]           bus_action,
  input wire logic                 requester_writeback,
  input wire logic [1:0]           requester_state,
  input wire logic [1:0]           snooper_state,
  input wire logic [WORD_BITS-1:0] word_even,
  input wire logic [WORD_BITS-1:0] word_odd
);

  import mtcc_pkg::*;

  // one transaction in flight at a time
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transaction accepted while another was in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(word_even) && $stable(word_odd)))
    else $error("stalled response changed");

  a_hit_bus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && hit) |->
      ((bus_action == BUS_NONE) || (bus_action == BUS_INV)) && !requester_writeback)
    else $error("hit with miss bus action or write-back");

  // snooper state is only known when the snoop matched its line
  a_rim_states: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((bus_action == BUS_RIM) || (bus_action == BUS_RIM_WB) ||
                   (bus_action == BUS_INV))) |->
      (requester_state == ST_M) &&
      ((bus_action != BUS_RIM_WB) || (snooper_state == ST_I)))
    else $error("exclusive bus action left inconsistent states");

  a_read_states: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((bus_action == BUS_READ) || (bus_action == BUS_READ_WB))) |->
      (requester_state == ST_S) &&
      ((bus_action != BUS_READ_WB) || (snooper_state == ST_S)))
    else $error("read miss left inconsistent states");

endmodule

bind msi_two_cache_coherence_core mtcc_checker #(
  .WORD_BITS (WORD_BITS)
) u_mtcc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_req.valid),
  .in_ready            (in_req.ready),
  .out_valid           (out_rsp.valid),
  .out_ready           (out_rsp.ready),
  .hit                 (out_rsp.hit),
  .bus_action          (out_rsp.bus_action),
  .requester_writeback (out_rsp.requester_writeback),
  .requester_state     (out_rsp.requester_state),
  .snooper_state       (out_rsp.snooper_state),
  .word_even           (out_rsp.word_even),
  .word_odd            (out_rsp.word_odd)
);

`default_nettype wire
